>>> rtl/rme_pkg.sv
// Shared constants for the modular exponentiation unit.
package rme_pkg;

  localparam int WORD_WIDTH_DEF = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] IDX_PUBLIC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] IDX_PRIVATE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] IDX_MODULUS = 2'd2;

  localparam logic [63:0] PUB_EXP_RESET = 64'd65537;

endpackage

>>> rtl/rme_req_if.sv
// Request channel: kind bit and data word.
interface rme_req_if
  import rme_pkg::*;
#(
  parameter int W = WORD_WIDTH_DEF
) ();
  logic         valid;
  logic         ready;
  logic         kind;
  logic [W-1:0] data_word;

  modport source (output valid, kind, data_word, input ready);
  modport sink (input valid, kind, data_word, output ready);
endinterface

>>> rtl/rme_res_if.sv
// Result channel: one result word per request.
interface rme_res_if
  import rme_pkg::*;
#(
  parameter int W = WORD_WIDTH_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] result_word;

  modport source (output valid, result_word, input ready);
  modport sink (input valid, result_word, output ready);
endinterface

>>> rtl/rme_cfg_if.sv
// Configuration write channel: register index and write data.
interface rme_cfg_if
  import rme_pkg::*;
#(
  parameter int W = WORD_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rsa_modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit.
// Raises each request's data word to the public (kind 0) or private (kind 1)
// exponent modulo the configured modulus, scanning the exponent from its LSB.
// Channels: cfg writes registers (index 0 public exponent, 1 private exponent,
// 2 modulus; a zero modulus write is dropped); req takes kind and data_word;
// res returns result_word, one per request.
// Order of work: the data word is reduced first, then each exponent bit up to
// the highest set bit takes one multiply-and-square pass, then the result
// goes into the output register. Two bit-serial multipliers (multiply and
// square side by side) do this work, one multiplier bit per cycle each. A zero
// exponent gives 1 without starting the multipliers; the request goes straight
// to the hold state and from there into the output register.
// One request is worked at a time; req.ready is high only while idle.
// The result sits in an output register, so the next request may be taken
// while res is stalled; a finished result then waits until res is free.
// Reset returns the registers to public 65537, private 1, modulus 1, and
// drops any request in flight. cfg.ready is always high; write only when idle.
module rsa_modular_exponentiation_unit
  import rme_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  rme_cfg_if.sink cfg,
  rme_req_if.sink req,
  rme_res_if.source res
);

  localparam int W = WORD_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]   state;
  logic [W-1:0] public_exponent;
  logic [W-1:0] private_exponent;
  logic [W-1:0] modulus;
  logic [W-1:0] exp_r;
  logic [W-1:0] acc;
  logic [W-1:0] run;
  logic         res_valid;
  logic [W-1:0] res_word;

  logic         accept;
  logic [W-1:0] exp_sel;
  logic [W-1:0] one_mod;
  logic         start0;
  logic         start1;
  logic [W-1:0] a0;
  logic [W-1:0] b0;
  logic         done0;
  logic         done1;
  logic [W-1:0] p0;
  logic [W-1:0] p1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent  <= PUB_EXP_RESET[W-1:0];
      private_exponent <= W'(1);
      modulus          <= W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        IDX_PUBLIC:  public_exponent <= cfg.data;
        IDX_PRIVATE: private_exponent <= cfg.data;
        IDX_MODULUS: begin
          if (cfg.data != '0) modulus <= cfg.data;
        end
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign exp_sel   = req.kind ? private_exponent : public_exponent;
  assign one_mod   = (modulus == W'(1)) ? '0 : W'(1);

  assign start0 = (accept && exp_sel != '0) || (state == S_STEP);
  assign start1 = (state == S_STEP);
  assign a0     = (state == S_IDLE) ? one_mod : acc;
  assign b0     = (state == S_IDLE) ? req.data_word : run;

  rme_modmul #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(start0), .a(a0), .b(b0), .n(modulus),
    .done(done0), .product(p0)
  );

  rme_modmul #(.W(W)) u_sqr (
    .clk(clk), .rst(rst), .start(start1), .a(run), .b(run), .n(modulus),
    .done(done1), .product(p1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != S_HOLD) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            exp_r <= exp_sel;
            if (exp_sel == '0) begin
              acc   <= W'(1);
              state <= S_HOLD;
            end else begin
              acc   <= one_mod;
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (done0) begin
            run   <= p0;
            state <= S_STEP;
          end
        end
        S_STEP: state <= S_MUL;
        S_MUL: begin
          if (done1) begin
            if (exp_r[0]) acc <= p0;
            run   <= p1;
            exp_r <= exp_r >> 1;
            state <= (exp_r[W-1:1] == '0) ? S_HOLD : S_STEP;
          end
        end
        S_HOLD: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_word  <= acc;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.result_word = res_word;

endmodule

>>> rtl/rme_modmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
module rme_modmul
  import rme_pkg::*;
#(
  parameter int W = WORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] product
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  n_r;
  logic [W-1:0]  acc;
  logic [W-1:0]  dbl;
  logic [W-1:0]  acc_next;

  // (x + y) mod m for x, y < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  always_comb begin
    dbl = add_mod(acc, acc, n_r);
    acc_next = b_r[W-1] ? add_mod(dbl, a_r, n_r) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      n_r <= n;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the RSA modular exponentiation unit.
module testbench;
  import rme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic                   KIND_ENCRYPT = 1'b0;
  localparam logic                   KIND_DECRYPT = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED   = 2'd3;
  localparam logic [63:0]            ALL_ONES     = '1;
  localparam logic [63:0]            TOP_BIT      = 64'h8000_0000_0000_0000;
  localparam logic [63:0]            PRIME_64     = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam int                     RAND_PHASES    = 7;
  localparam int                     PHASE_REQUESTS = 17;
  localparam int                     PRESSURE_PHASE = 1;
  localparam int                     FULL_PHASE     = 4;
  localparam int                     HOLD_CYCLES    = 3000;
  localparam int                     DRAIN_CYCLES   = 200;
  localparam int                     CYCLE_LIMIT    = 3_000_000;

  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] index;
    logic                   kind;
    logic [63:0]            value;
    logic                   typed;
    logic [63:0]            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rme_cfg_if cfg_ch ();
  rme_req_if req_ch ();
  rme_res_if res_ch ();

  rsa_modular_exponentiation_unit dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the key registers
  logic [63:0] pub_exp = PUB_EXP_RESET;
  logic [63:0] priv_exp = 64'd1;
  logic [63:0] modulus_reg = 64'd1;

  logic [63:0] expected_powers[$];
  logic [63:0] want_word;
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned ready_gap = 0;
  int unsigned hold_left = 0;
  stim_row_t   directed_rows[$];

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod % {64'd0, n};
    return prod[63:0];
  endfunction

  function automatic logic [63:0] predict_power(input logic kind, input logic [63:0] data);
    logic [63:0] expo;
    logic [63:0] base;
    logic [63:0] acc;
    expo = (kind == KIND_DECRYPT) ? priv_exp : pub_exp;
    if (expo == 64'd0) return 64'd1;
    base = data % modulus_reg;
    acc = 64'd1 % modulus_reg;
    for (int i = 0; i < 64; i++) begin
      if (expo[i]) acc = mul_mod(acc, base, modulus_reg);
      base = mul_mod(base, base, modulus_reg);
    end
    return acc;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [63:0] val);
    stim_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  function automatic stim_row_t request_row(input logic kind, input logic [63:0] data,
                                            input logic typed, input logic [63:0] want);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.value = data;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic [63:0] pick_modulus();
    case ($urandom_range(0, 6))
      0: return ALL_ONES;
      1: return 64'd1;
      2: return 64'($urandom_range(1, 255));
      3: return {32'd0, $urandom | 32'd1};
      4: return TOP_BIT;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [63:0] pick_exponent(input int phase);
    if (phase == FULL_PHASE) return rand_word() | TOP_BIT;
    if (phase == PRESSURE_PHASE) return 64'($urandom_range(1, 31));
    if ($urandom_range(0, 5) == 0) return 64'd0;
    return rand_word() & ((64'd1 << $urandom_range(1, 12)) - 64'd1);
  endfunction

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return ALL_ONES;
      2: return modulus_reg - 64'd1;
      3: return modulus_reg;
      default: return rand_word();
    endcase
  endfunction

  // lower the request valid and wait until every result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  // cfg valid is left high so that back-to-back writes follow each other without a gap
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      IDX_PUBLIC: pub_exp = val;
      IDX_PRIVATE: priv_exp = val;
      IDX_MODULUS: if (val != 64'd0) modulus_reg = val;
      default: ;
    endcase
  endtask

  task automatic send_request(input logic kind, input logic [63:0] data,
                              input logic typed, input logic [63:0] want);
    int unsigned gap;
    cfg_ch.valid <= 1'b0;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.data_word <= data;
    do @(posedge clk); while (!req_ch.ready);
    expected_powers.push_back(typed ? want : predict_power(kind, data));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_gap <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      res_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (ready_gap != 0) begin
      res_ch.ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      ready_gap <= pick_gap();
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %h",
                 $time, res_ch.result_word);
        errors++;
      end else begin
        want_word = expected_powers.pop_front();
        if (res_ch.result_word !== want_word) begin
          $display("%0t: result_word mismatch, expected %h, got %h",
                   $time, want_word, res_ch.result_word);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;

    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = 1'b0;
    req_ch.data_word = '0;

    // after reset: public 65537, private 1, modulus 1
    directed_rows.push_back(request_row(KIND_ENCRYPT, 64'd5, 1'b1, 64'd0));
    directed_rows.push_back(request_row(KIND_DECRYPT, ALL_ONES, 1'b1, 64'd0));
    directed_rows.push_back(write_row(IDX_MODULUS, 64'd0));
    directed_rows.push_back(request_row(KIND_ENCRYPT, 64'd7, 1'b1, 64'd0));
    directed_rows.push_back(write_row(IDX_UNUSED, 64'd123));
    directed_rows.push_back(write_row(IDX_MODULUS, ALL_ONES));
    directed_rows.push_back(write_row(IDX_PUBLIC, 64'd0));
    directed_rows.push_back(request_row(KIND_ENCRYPT, ALL_ONES, 1'b1, 64'd1));
    directed_rows.push_back(request_row(KIND_DECRYPT, ALL_ONES, 1'b1, 64'd0));
    directed_rows.push_back(request_row(KIND_DECRYPT, ALL_ONES - 64'd1, 1'b1,
                                        ALL_ONES - 64'd1));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd0, 1'b1, 64'd0));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd1, 1'b1, 64'd1));
    directed_rows.push_back(write_row(IDX_PUBLIC, 64'd2));
    directed_rows.push_back(request_row(KIND_ENCRYPT, ALL_ONES - 64'd1, 1'b1, 64'd1));
    directed_rows.push_back(request_row(KIND_ENCRYPT, 64'h1_0000_0000, 1'b1, 64'd1));
    directed_rows.push_back(write_row(IDX_PRIVATE, ALL_ONES));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd2, 1'b0, 64'd0));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd0, 1'b1, 64'd0));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd1, 1'b1, 64'd1));
    // Fermat: a^(p-1) = 1 mod p
    directed_rows.push_back(write_row(IDX_MODULUS, PRIME_64));
    directed_rows.push_back(write_row(IDX_PRIVATE, PRIME_64 - 64'd1));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd3, 1'b1, 64'd1));
    directed_rows.push_back(request_row(KIND_DECRYPT, ALL_ONES, 1'b0, 64'd0));
    directed_rows.push_back(request_row(KIND_DECRYPT, PRIME_64, 1'b1, 64'd0));
    directed_rows.push_back(write_row(IDX_MODULUS, 64'd1));
    directed_rows.push_back(write_row(IDX_PUBLIC, 64'd0));
    directed_rows.push_back(request_row(KIND_ENCRYPT, 64'd5, 1'b1, 64'd1));
    directed_rows.push_back(write_row(IDX_MODULUS, TOP_BIT));
    directed_rows.push_back(write_row(IDX_PUBLIC, 64'hFFFF));
    directed_rows.push_back(request_row(KIND_ENCRYPT, 64'd3, 1'b0, 64'd0));
    directed_rows.push_back(request_row(KIND_ENCRYPT, ALL_ONES, 1'b0, 64'd0));
    directed_rows.push_back(write_row(IDX_MODULUS, 64'd2));
    directed_rows.push_back(write_row(IDX_PRIVATE, TOP_BIT));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd3, 1'b1, 64'd1));
    directed_rows.push_back(request_row(KIND_DECRYPT, 64'd2, 1'b1, 64'd0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_write) begin
        drain_results();
        write_reg(row.index, row.value);
      end else begin
        send_request(row.kind, row.value, row.typed, row.want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      quiet = ($urandom_range(0, 2) == 0) && (p != PRESSURE_PHASE);
      if ($urandom_range(0, 3) == 0) write_reg(IDX_UNUSED, rand_word());
      if ($urandom_range(0, 3) == 0) write_reg(IDX_MODULUS, 64'd0);
      write_reg(IDX_MODULUS, pick_modulus());
      write_reg(IDX_PUBLIC, pick_exponent(p));
      write_reg(IDX_PRIVATE, pick_exponent(p));
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      for (int n = 0; n < PHASE_REQUESTS; n++)
        send_request(1'($urandom_range(0, 1)), pick_data(), 1'b0, 64'd0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rme_pkg.sv
rtl/rme_req_if.sv
rtl/rme_res_if.sv
rtl/rme_cfg_if.sv
rtl/rme_modmul.sv
rtl/rsa_modular_exponentiation_unit.sv
verif/testbench.sv
